// ===== sv/pst_pkg.sv =====
// ----------------------------------------------------------------------------
// pst_pkg: shared types and constants for the priority scheduler
// Request/response payload structs, the job record passed from the loader
// to the timing stage, and the loader state encoding.
// ----------------------------------------------------------------------------
package pst_pkg;

   localparam int MAX_JOBS_DEFAULT = 16;
   localparam int PRIO_W           = 16;
   localparam int BURST_W          = 16;
   localparam int ID_W             = 5;
   localparam int TIME_W           = 20;
   localparam int QUEUE_DEPTH      = 4;
   localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   typedef struct packed {
      logic [PRIO_W-1:0]  job_priority;
      logic [BURST_W-1:0] job_burst;
      logic               last_job;
   } pst_req_type;

   typedef struct packed {
      logic [ID_W-1:0]    job_id;
      logic [PRIO_W-1:0]  out_priority;
      logic [BURST_W-1:0] out_burst;
      logic [TIME_W-1:0]  completion_time;
      logic [TIME_W-1:0]  turnaround_time;
      logic [TIME_W-1:0]  waiting_time;
      logic               batch_overflow;
      logic               last_result;
   } pst_rsp_type;

   // One sorted job on its way to the timing stage
   typedef struct packed {
      logic [ID_W-1:0]    job_id;
      logic [PRIO_W-1:0]  job_priority;
      logic [BURST_W-1:0] job_burst;
      logic               batch_overflow;
      logic               last_result;
   } pst_job_type;

   typedef enum logic {
      ST_LOAD,
      ST_DRAIN
   } pst_state_type;

endpackage

// ===== sv/pst_front.sv =====
// ----------------------------------------------------------------------------
// pst_front: job loader with sorted insertion chain
// Each job that fits drops into its place in a chain of cells in priority
// order (ties by load order). A last job switches to draining, which shifts
// the chain out head first into the queue, one job per cycle while it has room.
// ----------------------------------------------------------------------------
module pst_front #(
   parameter int MAX_JOBS = pst_pkg::MAX_JOBS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  pst_pkg::pst_req_type req_data,
   input  logic                req_push,
   output logic                req_full,
   output pst_pkg::pst_job_type job_data,
   output logic                job_push,
   input  logic                job_full
);
   import pst_pkg::*;

   localparam int CNT_W = $clog2(MAX_JOBS + 1);
   localparam int IDC_W = (CNT_W + 1 > ID_W) ? CNT_W + 1 : ID_W;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_JOBS);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

   logic [PRIO_W-1:0]  prio_ff  [MAX_JOBS];
   logic [PRIO_W-1:0]  prio_in  [MAX_JOBS];
   logic [BURST_W-1:0] burst_ff [MAX_JOBS];
   logic [BURST_W-1:0] burst_in [MAX_JOBS];
   logic [ID_W-1:0]    id_ff    [MAX_JOBS];
   logic [ID_W-1:0]    id_in    [MAX_JOBS];
   logic [MAX_JOBS-1:0] ge;

   pst_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              dropped_ff, dropped_in;
   logic              accept, insert_en, drain_en;
   logic [IDC_W-1:0]  new_id_wide;
   logic [ID_W-1:0]   new_id;

   assign req_full    = (state_ff == ST_DRAIN);
   assign accept      = req_push && !req_full;
   assign insert_en   = accept && (count_ff < CNT_MAX);
   assign job_push    = (state_ff == ST_DRAIN) && !job_full;
   assign drain_en    = job_push;
   assign new_id_wide = IDC_W'(count_ff) + IDC_W'(1);
   assign new_id      = new_id_wide[ID_W-1:0];

   // Head of the chain goes to the queue
   always_comb begin
      job_data.job_id         = id_ff[0];
      job_data.job_priority   = prio_ff[0];
      job_data.job_burst      = burst_ff[0];
      job_data.batch_overflow = dropped_ff;
      job_data.last_result    = (count_ff == CNT_ONE);
   end

   // Loader control
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (insert_en) begin
                  count_in = count_ff + CNT_ONE;
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_data.last_job) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (drain_en) begin
               count_in = count_ff - CNT_ONE;
               if (count_ff == CNT_ONE) begin
                  state_in   = ST_LOAD;
                  dropped_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Occupied cells whose priority keeps them ahead of the new job
   always_comb begin
      for (int i = 0; i < MAX_JOBS; i++) begin
         ge[i] = (CNT_W'(i) < count_ff) && (prio_ff[i] >= req_data.job_priority);
      end
   end

   // Cell update: insert and shift down, or shift up while draining
   always_comb begin
      for (int i = 0; i < MAX_JOBS; i++) begin
         prio_in[i]  = prio_ff[i];
         burst_in[i] = burst_ff[i];
         id_in[i]    = id_ff[i];
         if (drain_en) begin
            if (i < MAX_JOBS - 1) begin
               prio_in[i]  = prio_ff[i+1];
               burst_in[i] = burst_ff[i+1];
               id_in[i]    = id_ff[i+1];
            end
         end else if (insert_en) begin
            if ((i == 0 || ge[i-1]) && !ge[i]) begin
               prio_in[i]  = req_data.job_priority;
               burst_in[i] = req_data.job_burst;
               id_in[i]    = new_id;
            end else if (i > 0 && !ge[i-1] && (CNT_W'(i) <= count_ff)) begin
               prio_in[i]  = prio_ff[i-1];
               burst_in[i] = burst_ff[i-1];
               id_in[i]    = id_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_JOBS; i++) begin
         prio_ff[i]  <= prio_in[i];
         burst_ff[i] <= burst_in[i];
         id_ff[i]    <= id_in[i];
      end
   end

endmodule

// ===== sv/pst_queue.sv =====
// ----------------------------------------------------------------------------
// pst_queue: short job queue between loader and timing stage
// Small register FIFO; lets the loader drain while the output is stalled.
// ----------------------------------------------------------------------------
module pst_queue (
   input  logic                clock,
   input  logic                reset,
   input  pst_pkg::pst_job_type push_data,
   input  logic                push,
   output logic                full,
   output pst_pkg::pst_job_type pop_data,
   input  logic                pop,
   output logic                empty
);
   import pst_pkg::*;

   pst_job_type        mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign full     = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // Pointer and fill update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/pst_back.sv =====
// ----------------------------------------------------------------------------
// pst_back: schedule time accumulator and result register
// Keeps the running time of the batch, saturating at the 20-bit limit,
// and holds one finished result until it is taken.
// ----------------------------------------------------------------------------
module pst_back (
   input  logic                clock,
   input  logic                reset,
   input  pst_pkg::pst_job_type job_data,
   input  logic                job_empty,
   output logic                job_pop,
   output pst_pkg::pst_rsp_type rsp_data,
   output logic                rsp_empty,
   input  logic                rsp_pop
);
   import pst_pkg::*;

   logic [TIME_W-1:0] elapsed_ff, elapsed_in;
   logic              valid_ff, valid_in;
   pst_rsp_type       rsp_ff, rsp_in;
   logic [TIME_W:0]   sum;
   logic [TIME_W-1:0] after;

   assign rsp_empty = !valid_ff;
   assign rsp_data  = rsp_ff;
   assign job_pop   = !job_empty && (!valid_ff || rsp_pop);

   // Running time with saturation
   assign sum   = {1'b0, elapsed_ff} + (TIME_W + 1)'(job_data.job_burst);
   assign after = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];

   always_comb begin
      elapsed_in = elapsed_ff;
      valid_in   = valid_ff;
      rsp_in     = rsp_ff;
      if (job_pop) begin
         valid_in               = 1'b1;
         elapsed_in             = job_data.last_result ? '0 : after;
         rsp_in.job_id          = job_data.job_id;
         rsp_in.out_priority    = job_data.job_priority;
         rsp_in.out_burst       = job_data.job_burst;
         rsp_in.completion_time = after;
         rsp_in.turnaround_time = after;
         rsp_in.waiting_time    = elapsed_ff;
         rsp_in.batch_overflow  = job_data.batch_overflow;
         rsp_in.last_result     = job_data.last_result;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         elapsed_ff <= elapsed_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

// ===== sv/priority_schedule_times.sv =====
// ----------------------------------------------------------------------------
// priority_schedule_times: non-preemptive priority scheduler for one batch
// Jobs load one per cycle unless full; a last job starts emission of the sorted batch.
// ----------------------------------------------------------------------------
// Jobs are taken one per cycle while loading; each that fits is placed into
// a sorted chain of MAX_JOBS cells in the cycle it is accepted. The transfer
// marked last_job starts draining: full stays high until every held job has
// left. One job per cycle, while the queue has room, leaves the chain
// through a four-entry queue into the timing stage, which presents one
// result per cycle while pop keeps up. A batch thus occupies the input for
// its transfers and then for the draining of its held jobs; each dropped job
// still takes a transfer, and a stalled output that fills the queue
// stretches the drain. Jobs beyond MAX_JOBS are dropped and every result of
// that batch shows batch_overflow.
module priority_schedule_times #(
   parameter int MAX_JOBS = pst_pkg::MAX_JOBS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  pst_pkg::pst_req_type req_data,
   input  logic                req_push,
   output logic                req_full,
   output pst_pkg::pst_rsp_type rsp_data,
   output logic                rsp_empty,
   input  logic                rsp_pop
);
   import pst_pkg::*;

   pst_job_type front_job, back_job;
   logic        front_push, queue_full, back_pop, queue_empty;

   pst_front #(.MAX_JOBS(MAX_JOBS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .req_push (req_push),
      .req_full (req_full),
      .job_data (front_job),
      .job_push (front_push),
      .job_full (queue_full)
   );

   pst_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_data (front_job),
      .push      (front_push),
      .full      (queue_full),
      .pop_data  (back_job),
      .pop       (back_pop),
      .empty     (queue_empty)
   );

   pst_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_data  (back_job),
      .job_empty (queue_empty),
      .job_pop   (back_pop),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

endmodule

// ===== sv/pst_checker.sv =====
// ----------------------------------------------------------------------------
// pst_checker: port-level checks for the priority scheduler
// Watches the top-level queue ports and checks result timing relations.
// ----------------------------------------------------------------------------
module pst_checker (
   input logic                clock,
   input logic                reset,
   input pst_pkg::pst_req_type req_data,
   input logic                req_push,
   input logic                req_full,
   input pst_pkg::pst_rsp_type rsp_data,
   input logic                rsp_empty,
   input logic                rsp_pop
);
   import pst_pkg::*;

   // Nothing to show right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result present right after reset");

   // A waiting result holds until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("waiting result changed or vanished");

   // Last job of a batch closes the input for draining
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full && req_data.last_job) |=> req_full)
      else $error("input still open after last job");

   // Turnaround equals completion
   a_turnaround: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.turnaround_time == rsp_data.completion_time))
      else $error("turnaround differs from completion");

   // Waiting plus burst gives completion unless the time saturated
   a_waiting: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_data.completion_time != TIME_MAX)) |->
      (({1'b0, rsp_data.waiting_time} + (TIME_W + 1)'(rsp_data.out_burst))
       == {1'b0, rsp_data.completion_time}))
      else $error("waiting time inconsistent with completion");

endmodule

bind priority_schedule_times pst_checker u_pst_checker (
   .clock     (clock),
   .reset     (reset),
   .req_data  (req_data),
   .req_push  (req_push),
   .req_full  (req_full),
   .rsp_data  (rsp_data),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop)
);

// ===== tb/tb_priority_schedule_times.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_priority_schedule_times: self-checking bench for the priority scheduler
// Loads batches of jobs through the request queue and checks every scheduled
// result against a sorted-store predictor; directed corners first, then
// random batches under varying idle, stall and backpressure patterns.
// ----------------------------------------------------------------------------
module tb_priority_schedule_times;
   import pst_pkg::*;

   localparam int JOBS       = MAX_JOBS_DEFAULT;
   localparam int QUIET_MAX  = 1000;   // cycles with no transfer before giving up
   localparam int HOLD_LEN   = 120;    // long receiver hold-off
   localparam int TAIL_LEN   = 40;     // drain time after the last expected result
   localparam int PHASE_JOBS = 137;

   typedef struct {
      pst_req_type stim;
      bit          typed;
      pst_rsp_type want;
   } dir_row_type;

   logic        clock;
   logic        reset    = 1'b1;
   pst_req_type req_data = '0;
   logic        req_push = 1'b0;
   logic        req_full;
   pst_rsp_type rsp_data;
   logic        rsp_empty;
   logic        rsp_pop  = 1'b0;

   // Predictor state: sorted job store of the batch being loaded
   logic [PRIO_W-1:0]  held_prio  [JOBS];
   logic [BURST_W-1:0] held_burst [JOBS];
   logic [ID_W-1:0]    held_id    [JOBS];
   int                 held_count   = 0;
   bit                 held_dropped = 0;

   pst_rsp_type due_schedule[$];
   int          mismatch_count = 0;
   int          send_idle_pct  = 15;
   int          rcv_idle_pct   = 48;
   bit          hold_request   = 0;
   int          quiet_cycles   = 0;
   dir_row_type dir_rows[$];

   priority_schedule_times u_top (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .req_push  (req_push),
      .req_full  (req_full),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // Insert one accepted job; on the last job queue the whole schedule
   function automatic void book_job(input pst_req_type d);
      int          pos;
      int          elapsed;
      int          after;
      pst_rsp_type r;
      if (held_count < JOBS) begin
         pos = held_count;
         // equal priorities keep load order, so shift only strictly lower ones
         while (pos > 0 && held_prio[pos-1] < d.job_priority) begin
            held_prio[pos]  = held_prio[pos-1];
            held_burst[pos] = held_burst[pos-1];
            held_id[pos]    = held_id[pos-1];
            pos--;
         end
         held_prio[pos]  = d.job_priority;
         held_burst[pos] = d.job_burst;
         held_id[pos]    = ID_W'(held_count + 1);
         held_count++;
      end else begin
         held_dropped = 1;
      end
      if (d.last_job) begin
         elapsed = 0;
         for (int k = 0; k < held_count; k++) begin
            after = elapsed + held_burst[k];
            if (after > int'(TIME_MAX))
               after = int'(TIME_MAX);
            r.job_id          = held_id[k];
            r.out_priority    = held_prio[k];
            r.out_burst       = held_burst[k];
            r.completion_time = TIME_W'(after);
            r.turnaround_time = TIME_W'(after);
            r.waiting_time    = TIME_W'(elapsed);
            r.batch_overflow  = held_dropped;
            r.last_result     = (k == held_count - 1);
            due_schedule.push_back(r);
            elapsed = after;
         end
         held_count   = 0;
         held_dropped = 0;
      end
   endfunction

   task automatic compare_field(input string name, input int unsigned got,
                                input int unsigned want);
      if (got != want)
         report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
   endtask

   task automatic check_result(input pst_rsp_type got);
      pst_rsp_type want;
      if (due_schedule.size() == 0) begin
         report_mismatch($sformatf("result with nothing scheduled, job_id %0d", got.job_id));
      end else begin
         want = due_schedule.pop_front();
         compare_field("job_id", got.job_id, want.job_id);
         compare_field("out_priority", got.out_priority, want.out_priority);
         compare_field("out_burst", got.out_burst, want.out_burst);
         compare_field("completion_time", got.completion_time, want.completion_time);
         compare_field("turnaround_time", got.turnaround_time, want.turnaround_time);
         compare_field("waiting_time", got.waiting_time, want.waiting_time);
         compare_field("batch_overflow", got.batch_overflow, want.batch_overflow);
         compare_field("last_result", got.last_result, want.last_result);
      end
   endtask

   // Offer one job until it transfers, then book it
   task automatic send_job(input pst_req_type d, input bit typed, input pst_rsp_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_data <= d;
      req_push <= 1'b1;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      book_job(d);
      // a hand-typed answer replaces the single prediction of its batch
      if (typed) begin
         void'(due_schedule.pop_back());
         due_schedule.push_back(want);
      end
   endtask

   // One random batch; returns the number of jobs offered
   task automatic send_batch(output int jobs);
      int          size_pick;
      int          prio_mode;
      pst_req_type d;
      size_pick = $urandom_range(99);
      if (size_pick < 10)
         jobs = $urandom_range(JOBS + 1, JOBS + 4);
      else if (size_pick < 20)
         jobs = JOBS;
      else
         jobs = $urandom_range(1, JOBS);
      prio_mode = $urandom_range(2);
      for (int i = 0; i < jobs; i++) begin
         case (prio_mode)
            0: d.job_priority = PRIO_W'($urandom_range(3));
            1: d.job_priority = $urandom_range(1) ? '1 : '0;
            default: d.job_priority = PRIO_W'($urandom);
         endcase
         case ($urandom_range(9))
            0: d.job_burst = '0;
            1: d.job_burst = '1;
            default: d.job_burst = BURST_W'($urandom);
         endcase
         d.last_job = (i == jobs - 1);
         send_job(d, 1'b0, '0);
      end
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      while (due_schedule.size() != 0)
         @(posedge clock);
   endtask

   function automatic dir_row_type plain_row(input int prio, input int burst, input bit last);
      dir_row_type r;
      r.stim  = '{job_priority: PRIO_W'(prio), job_burst: BURST_W'(burst), last_job: last};
      r.typed = 1'b0;
      r.want  = '0;
      return r;
   endfunction

   // Receiver: random pop idling, plus one long hold-off on request
   initial begin
      bit pop;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_request) begin
            rsp_pop <= 1'b0;
            for (int c = 0; c < HOLD_LEN; c++)
               @(posedge clock);
            hold_request = 0;
         end else begin
            pop = ($urandom_range(99) >= rcv_idle_pct);
            rsp_pop <= pop;
            @(posedge clock);
            if (pop && !rsp_empty)
               check_result(rsp_data);
         end
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_MAX) begin
         $display("Timeout: no transfer for %0d cycles", QUIET_MAX);
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Main sequence
   initial begin
      int          sent;
      int          jobs;
      dir_row_type r;

      // directed rows: single-job extremes, tie ordering, overflow batch
      r.stim  = '{job_priority: '1, job_burst: '1, last_job: 1'b1};
      r.typed = 1'b1;
      r.want  = '{job_id: 5'd1, out_priority: '1, out_burst: '1,
                  completion_time: 20'h0FFFF, turnaround_time: 20'h0FFFF,
                  waiting_time: '0, batch_overflow: 1'b0, last_result: 1'b1};
      dir_rows.push_back(r);
      r.stim  = '0;
      r.stim.last_job = 1'b1;
      r.want  = '{job_id: 5'd1, out_priority: '0, out_burst: '0,
                  completion_time: '0, turnaround_time: '0,
                  waiting_time: '0, batch_overflow: 1'b0, last_result: 1'b1};
      dir_rows.push_back(r);
      dir_rows = '{dir_rows[0], dir_rows[1],
         plain_row(16'h0005, 10, 0), plain_row(16'h0009, 3, 0),
         plain_row(16'h0005, 7, 0),  plain_row(16'h0009, 0, 1),
         plain_row(16'h0000, 16'hFFFF, 0), plain_row(16'hFFFF, 16'hFFFF, 0),
         plain_row(16'h8000, 16'hFFFF, 0), plain_row(16'h8000, 16'hFFFF, 0),
         plain_row(16'h0001, 16'hFFFF, 0), plain_row(16'hFFFE, 16'hFFFF, 0),
         plain_row(16'h7FFF, 16'hFFFF, 0), plain_row(16'h0000, 16'hFFFF, 0),
         plain_row(16'hFFFF, 16'hFFFF, 0), plain_row(16'h1234, 16'hFFFF, 0),
         plain_row(16'h8000, 16'hFFFF, 0), plain_row(16'h0000, 16'hFFFF, 0),
         plain_row(16'hABCD, 16'hFFFF, 0), plain_row(16'h5555, 16'hFFFF, 0),
         plain_row(16'hAAAA, 16'hFFFF, 0), plain_row(16'hFFFF, 16'hFFFF, 0),
         plain_row(16'hFFFF, 16'h0001, 0), plain_row(16'h0000, 16'h0002, 1)};

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_job(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
      wait_drained();

      // random batches in three idling phases
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 15; rcv_idle_pct = 48; hold_request = 1; end
            1: begin send_idle_pct = 48; rcv_idle_pct = 15; end
            default: begin send_idle_pct = 0; rcv_idle_pct = 0; end
         endcase
         sent = 0;
         while (sent < PHASE_JOBS) begin
            send_batch(jobs);
            sent += jobs;
         end
         // sender pauses until the whole schedule has come back
         wait_drained();
      end

      repeat (TAIL_LEN) @(posedge clock);
      if (due_schedule.size() != 0)
         report_mismatch($sformatf("%0d scheduled results never arrived",
                                   due_schedule.size()));
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== priority_schedule_times.f =====
sv/pst_pkg.sv
sv/pst_front.sv
sv/pst_queue.sv
sv/pst_back.sv
sv/priority_schedule_times.sv
sv/pst_checker.sv
tb/tb_priority_schedule_times.sv
